// ===== src/included_region_next_lookup_core_assert.svh =====
// Assertion macros for the region lookup core.
// Used by modules that declare clk and arst_n; no other dependencies.
`ifndef INCLUDED_REGION_NEXT_LOOKUP_CORE_ASSERT_SVH
`define INCLUDED_REGION_NEXT_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IRNL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irnl assertion failed");

// next-cycle implication, disabled in reset
`define IRNL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irnl assertion failed");

`endif

// ===== src/irnl_pkg.sv =====
// Shared types and constants for the region lookup core.
// No dependencies; used by the other src files except irnl_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

package irnl_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int ADDR_WIDTH_DEF  = 32;

	// fixed field widths of the channels
	localparam int CMD_W    = 2;
	localparam int FIELD_W  = 32;
	localparam int ENTRY_W  = 6;
	localparam int STATUS_W = 2;
	localparam int HELD_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_MARK   = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_find;
		logic scan_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== src/irnl_req_if.sv =====
// Request channel interface: valid/ready plus command payload.
// Depends on irnl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface irnl_req_if;
	logic                          valid;
	logic                          ready;
	logic [irnl_pkg::CMD_W-1:0]    cmd;
	logic [irnl_pkg::FIELD_W-1:0]  region_start;
	logic [irnl_pkg::FIELD_W-1:0]  region_end;
	logic [irnl_pkg::ENTRY_W-1:0]  target_entry;
	logic [irnl_pkg::FIELD_W-1:0]  query_address;

	modport source (
		output valid, cmd, region_start, region_end, target_entry, query_address,
		input  ready
	);
	modport sink (
		input  valid, cmd, region_start, region_end, target_entry, query_address,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/irnl_rsp_if.sv =====
// Response channel interface: valid/ready plus result payload.
// Depends on irnl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface irnl_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [irnl_pkg::ENTRY_W-1:0]   result_entry;
	logic [irnl_pkg::STATUS_W-1:0]  status;
	logic [irnl_pkg::HELD_W-1:0]    entries_held;

	modport source (
		output valid, found, result_entry, status, entries_held,
		input  ready
	);
	modport sink (
		input  valid, found, result_entry, status, entries_held,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/irnl_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module irnl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/irnl_ctrl.sv =====
// Controller FSM: sequences accept, execute, table scan and response.
// Depends on irnl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "included_region_next_lookup_core_assert.svh"

module irnl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output      logic                 req_ready,
	output      logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	output      irnl_pkg::ctrl_cmd_t  ctl,
	input  wire irnl_pkg::dp_stat_t   stat
);

	irnl_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irnl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		req_ready    = 1'b0;
		unique case (state_q)
			irnl_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				ctl.capture = req_valid;
				if (req_valid) begin
					state_d = irnl_pkg::S_EXEC;
				end
			end
			irnl_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = stat.is_find ? irnl_pkg::S_SCAN : irnl_pkg::S_RESP;
			end
			irnl_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = irnl_pkg::S_RESP;
				end
			end
			irnl_pkg::S_RESP: begin
				// wait until the output register is free
				ctl.load_out = !out_valid_q || rsp_ready;
				if (ctl.load_out) begin
					state_d = irnl_pkg::S_IDLE;
				end
			end
			default: state_d = irnl_pkg::S_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;

	`IRNL_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_q == irnl_pkg::S_EXEC)
	`IRNL_ASSERT_NEXT(a_find_scans, state_q == irnl_pkg::S_EXEC && stat.is_find,
		state_q == irnl_pkg::S_SCAN)
	`IRNL_ASSERT_NOW(a_rsp_from_resp, $rose(out_valid_q),
		$past(state_q) == irnl_pkg::S_RESP)
	`IRNL_ASSERT_NEXT(a_resp_loads, state_q == irnl_pkg::S_RESP && (!out_valid_q || rsp_ready),
		out_valid_q && state_q == irnl_pkg::S_IDLE)

endmodule

`default_nettype wire

// ===== src/irnl_dp.sv =====
// Datapath: command registers, region table RAMs, scan and result registers.
// Depends on irnl_pkg and irnl_ram.
`timescale 1ns / 1ps
`default_nettype none

module irnl_dp #(
	parameter int MAX_ENTRIES = irnl_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_WIDTH  = irnl_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire irnl_pkg::ctrl_cmd_t              ctl,
	output      irnl_pkg::dp_stat_t               stat,
	input  wire logic [irnl_pkg::CMD_W-1:0]       cmd,
	input  wire logic [irnl_pkg::FIELD_W-1:0]     region_start,
	input  wire logic [irnl_pkg::FIELD_W-1:0]     region_end,
	input  wire logic [irnl_pkg::ENTRY_W-1:0]     target_entry,
	input  wire logic [irnl_pkg::FIELD_W-1:0]     query_address,
	output      logic                             found,
	output      logic [irnl_pkg::ENTRY_W-1:0]     result_entry,
	output      logic [irnl_pkg::STATUS_W-1:0]    status,
	output      logic [irnl_pkg::HELD_W-1:0]      entries_held
);

	localparam int AW = ADDR_WIDTH;
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int TW = (CW > irnl_pkg::ENTRY_W) ? CW : irnl_pkg::ENTRY_W;

	// captured command
	irnl_pkg::cmd_t              cmd_q;
	logic [AW-1:0]               rstart_q, rend_q, query_q;
	logic [irnl_pkg::ENTRY_W-1:0] target_q;

	logic [CW-1:0]               count_q;
	logic [CW-1:0]               scan_idx_q;
	logic                        pend_s1;
	logic [IW-1:0]               idx_s1;
	logic                        hit_q, have_q;
	logic [AW-1:0]               cand_start_q;
	logic [IW-1:0]               best_idx_q;
	logic [irnl_pkg::ENTRY_W-1:0] res_entry_q;
	irnl_pkg::status_t           res_status_q;

	// table RAM ports
	logic                        se_we, inc_we, inc_wdata;
	logic [IW-1:0]               inc_waddr;
	logic [2*AW-1:0]             se_rdata;
	logic                        inc_rdata;
	logic [AW-1:0]               ent_start, ent_end;

	logic                        full, bad_idx, issue;
	logic                        ent_live, ent_hit, ent_cand;

	irnl_ram #(.WIDTH(2 * AW), .DEPTH(MAX_ENTRIES)) u_span_ram (
		.clk   (clk),
		.we    (se_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({rend_q, rstart_q}),
		.raddr (scan_idx_q[IW-1:0]),
		.rdata (se_rdata)
	);

	// marks need no reset: an append rewrites the mark before the entry counts
	irnl_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_mark_ram (
		.clk   (clk),
		.we    (inc_we),
		.waddr (inc_waddr),
		.wdata (inc_wdata),
		.raddr (scan_idx_q[IW-1:0]),
		.rdata (inc_rdata)
	);

	assign full    = count_q >= CW'(MAX_ENTRIES);
	assign bad_idx = (TW'(target_q) >= TW'(count_q)) || (TW'(target_q) >= TW'(MAX_ENTRIES));

	always_comb begin
		se_we     = 1'b0;
		inc_we    = 1'b0;
		inc_wdata = 1'b0;
		inc_waddr = count_q[IW-1:0];
		if (ctl.exec) begin
			unique case (cmd_q)
				irnl_pkg::CMD_APPEND: begin
					se_we  = !full;
					inc_we = !full;
				end
				irnl_pkg::CMD_MARK: begin
					inc_we    = !bad_idx;
					inc_wdata = 1'b1;
					inc_waddr = IW'(target_q);
				end
				default: ;
			endcase
		end
	end

	assign ent_start = se_rdata[AW-1:0];
	assign ent_end   = se_rdata[2*AW-1:AW];
	// entries returned after a hit are ignored
	assign ent_live  = pend_s1 && !hit_q && inc_rdata && (query_q <= ent_end);
	assign ent_hit   = ent_live && (query_q >= ent_start);
	assign ent_cand  = ent_live && !(query_q >= ent_start) &&
		(!have_q || (ent_start < cand_start_q));
	assign issue     = ctl.scan && !hit_q && !ent_hit && (scan_idx_q < count_q);

	assign stat.is_find   = (cmd_q == irnl_pkg::CMD_FIND);
	assign stat.scan_done = hit_q || (!pend_s1 && !(scan_idx_q < count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
			hit_q      <= 1'b0;
			have_q     <= 1'b0;
		end else begin
			if (ctl.exec) begin
				unique case (cmd_q)
					irnl_pkg::CMD_CLEAR:  count_q <= '0;
					irnl_pkg::CMD_APPEND: if (!full) count_q <= count_q + CW'(1);
					irnl_pkg::CMD_MARK:   ;
					irnl_pkg::CMD_FIND: begin
						scan_idx_q <= '0;
						pend_s1    <= 1'b0;
						hit_q      <= 1'b0;
						have_q     <= 1'b0;
					end
					default: ;
				endcase
			end
			if (ctl.scan) begin
				pend_s1 <= issue;
				if (issue) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				if (ent_hit) begin
					hit_q <= 1'b1;
				end else if (ent_cand) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= irnl_pkg::cmd_t'(cmd);
			rstart_q <= AW'(region_start);
			rend_q   <= AW'(region_end);
			target_q <= target_entry;
			query_q  <= AW'(query_address);
		end
		if (ctl.scan) begin
			idx_s1 <= scan_idx_q[IW-1:0];
			if (ent_hit) begin
				best_idx_q <= idx_s1;
			end else if (ent_cand) begin
				best_idx_q   <= idx_s1;
				cand_start_q <= ent_start;
			end
		end
		if (ctl.exec) begin
			unique case (cmd_q)
				irnl_pkg::CMD_APPEND: begin
					res_entry_q  <= full ? '0 : irnl_pkg::ENTRY_W'(count_q);
					res_status_q <= full ? irnl_pkg::ST_FULL : irnl_pkg::ST_OK;
				end
				irnl_pkg::CMD_MARK: begin
					res_entry_q  <= target_q;
					res_status_q <= bad_idx ? irnl_pkg::ST_RANGE : irnl_pkg::ST_OK;
				end
				default: begin
					res_entry_q  <= '0;
					res_status_q <= irnl_pkg::ST_OK;
				end
			endcase
		end
		if (ctl.load_out) begin
			status       <= res_status_q;
			entries_held <= irnl_pkg::HELD_W'(count_q);
			if (stat.is_find) begin
				found        <= hit_q || have_q;
				result_entry <= (hit_q || have_q) ? irnl_pkg::ENTRY_W'(best_idx_q) : '0;
			end else begin
				found        <= 1'b0;
				result_entry <= res_entry_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/included_region_next_lookup_core.sv =====
// Included-region table with next-included lookup, top level.
// Depends on irnl_pkg, irnl_req_if, irnl_rsp_if, irnl_ctrl and irnl_dp.
//
// Usage:
//   req carries one command per transaction: clear, append region, mark an
//   entry included, or find the next included region from an address.
//   rsp returns exactly one result transaction per command, in order.
//   req.ready is high only while the core is idle; one command is in
//   flight at a time. A finished result sits in the rsp output register,
//   so the next command is taken while that result waits to be taken.
//   From acceptance, clear, append and mark pass through the EXEC and RESP
//   states into the rsp output register; a find adds the SCAN state, which
//   scans the table one entry per cycle through the registered RAM read
//   port and stops early when a containing entry is hit.
//   req.ready returns in the cycle the result is loaded into the rsp output
//   register; no command is taken before the last one's result is loaded.
//   Reset clears the entry count and the control state at once; the table
//   RAMs are not cleared, appends overwrite them before they are read.
//   If rsp.ready stays low, the core finishes the next command and then
//   holds it until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module included_region_next_lookup_core #(
	parameter int MAX_ENTRIES = irnl_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_WIDTH  = irnl_pkg::ADDR_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	irnl_req_if.sink  req,
	irnl_rsp_if.source rsp
);

	irnl_pkg::ctrl_cmd_t ctl;
	irnl_pkg::dp_stat_t  stat;

	irnl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	irnl_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (req.cmd),
		.region_start  (req.region_start),
		.region_end    (req.region_end),
		.target_entry  (req.target_entry),
		.query_address (req.query_address),
		.found         (rsp.found),
		.result_entry  (rsp.result_entry),
		.status        (rsp.status),
		.entries_held  (rsp.entries_held)
	);

endmodule

`default_nettype wire

// ===== dv/included_region_next_lookup_core_tb.sv =====
// Self-checking testbench for included_region_next_lookup_core.
// Runs directed and random command traffic against a built-in table predictor.
// Depends on irnl_pkg, irnl_req_if, irnl_rsp_if and the core RTL.
`timescale 1ns / 1ps

module included_region_next_lookup_core_tb;
	import irnl_pkg::*;

	localparam int TBL_DEPTH = MAX_ENTRIES_DEF;

	typedef logic [FIELD_W-1:0] addr_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [HELD_W-1:0]  held_t;

	typedef struct {
		cmd_t   op;
		addr_t  rstart;
		addr_t  rend;
		entry_t target;
		addr_t  query;
	} region_cmd_t;

	typedef struct {
		logic    found;
		entry_t  entry;
		status_t status;
		held_t   held;
	} region_reply_t;

	typedef struct {
		region_cmd_t   c;
		bit            fixed;
		region_reply_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	irnl_req_if req_ch();
	irnl_rsp_if rsp_ch();

	included_region_next_lookup_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the region table
	addr_t            tbl_start [TBL_DEPTH];
	addr_t            tbl_end   [TBL_DEPTH];
	bit [TBL_DEPTH-1:0] tbl_incl;
	int unsigned      tbl_count;

	region_reply_t replies_pending[$];
	int            errors;
	bit            no_idle;
	addr_t         near_base;

	function automatic region_reply_t next_region_reply(input region_cmd_t c);
		region_reply_t rp;
		bit            have;
		bit            hit;
		addr_t         cand_start;
		int            best;
		rp = '{found: 1'b0, entry: '0, status: ST_OK, held: '0};
		have = 1'b0;
		hit = 1'b0;
		cand_start = '0;
		best = 0;
		case (c.op)
			CMD_CLEAR: begin
				tbl_count = 0;
				tbl_incl = '0;
			end
			CMD_APPEND: begin
				if (tbl_count >= TBL_DEPTH) begin
					rp.status = ST_FULL;
				end else begin
					tbl_start[tbl_count] = c.rstart;
					tbl_end[tbl_count] = c.rend;
					tbl_incl[tbl_count] = 1'b0;
					rp.entry = entry_t'(tbl_count);
					tbl_count++;
				end
			end
			CMD_MARK: begin
				rp.entry = c.target;
				if (c.target >= tbl_count)
					rp.status = ST_RANGE;
				else
					tbl_incl[c.target] = 1'b1;
			end
			default: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (!hit && tbl_incl[i] && c.query <= tbl_end[i]) begin
						if (c.query >= tbl_start[i]) begin
							hit = 1'b1;
							rp.found = 1'b1;
							rp.entry = entry_t'(i);
						end else if (!have || tbl_start[i] < cand_start) begin
							// strict compare keeps the lower index on ties
							have = 1'b1;
							cand_start = tbl_start[i];
							best = i;
						end
					end
				end
				if (!hit && have) begin
					rp.found = 1'b1;
					rp.entry = entry_t'(best);
				end
			end
		endcase
		rp.held = held_t'(tbl_count);
		return rp;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic addr_t rand_addr();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			default: return near_base + $urandom_range(0, 255);
		endcase
	endfunction

	// all fields random so that ignored fields toggle too
	function automatic region_cmd_t rand_fields(input cmd_t op);
		region_cmd_t c;
		c.op = op;
		c.rstart = $urandom();
		c.rend = $urandom();
		c.target = entry_t'($urandom());
		c.query = $urandom();
		return c;
	endfunction

	function automatic region_cmd_t rand_append();
		region_cmd_t c;
		int unsigned r;
		c = rand_fields(CMD_APPEND);
		c.rstart = rand_addr();
		r = $urandom_range(0, 9);
		if (r < 8)
			c.rend = c.rstart + $urandom_range(0, 64);
		else if (r == 8)
			c.rend = rand_addr();
		else
			c.rend = c.rstart - $urandom_range(1, 32);
		return c;
	endfunction

	function automatic region_cmd_t rand_find();
		region_cmd_t c;
		int unsigned i;
		c = rand_fields(CMD_FIND);
		if (tbl_count != 0 && $urandom_range(0, 9) < 7) begin
			i = $urandom_range(0, tbl_count - 1);
			case ($urandom_range(0, 5))
				0: c.query = tbl_start[i];
				1: c.query = tbl_end[i];
				2: c.query = tbl_start[i] - 1;
				3: c.query = tbl_end[i] + 1;
				4: c.query = tbl_start[i] + $urandom_range(0, 16);
				default: c.query = tbl_end[i] - $urandom_range(0, 16);
			endcase
		end else begin
			c.query = rand_addr();
		end
		return c;
	endfunction

	function automatic region_cmd_t rand_mark(input bit noise);
		region_cmd_t c;
		c = rand_fields(CMD_MARK);
		if (!noise && tbl_count != 0 && $urandom_range(0, 9) != 0)
			c.target = entry_t'($urandom_range(0, tbl_count - 1));
		return c;
	endfunction

	function automatic dir_row_t drow(input cmd_t op, input addr_t a, input addr_t b,
			input entry_t t, input addr_t q, input bit fixed, input logic f,
			input entry_t e, input status_t s, input held_t h);
		dir_row_t row;
		row.c = '{op: op, rstart: a, rend: b, target: t, query: q};
		row.fixed = fixed;
		row.r = '{found: f, entry: e, status: s, held: h};
		return row;
	endfunction

	task automatic issue_cmd(input region_cmd_t c, input bit fixed, input region_reply_t want);
		int unsigned   g;
		region_reply_t p;
		g = idle_len();
		if (g != 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c.op;
		req_ch.region_start <= c.rstart;
		req_ch.region_end <= c.rend;
		req_ch.target_entry <= c.target;
		req_ch.query_address <= c.query;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		// transaction accepted; table state advances in command order
		p = next_region_reply(c);
		replies_pending.push_back(fixed ? want : p);
	endtask

	task automatic issue_rand(input region_cmd_t c);
		region_reply_t none;
		none = '{found: 1'b0, entry: '0, status: ST_OK, held: '0};
		issue_cmd(c, 1'b0, none);
	endtask

	// response side: random backpressure
	initial begin
		int unsigned g;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			g = idle_len();
			if (g != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : rsp_check
		region_reply_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (replies_pending.size() == 0) begin
				$display("%0t: response with none pending: found=%0b entry=%0d status=%0d held=%0d",
					$time, rsp_ch.found, rsp_ch.result_entry, rsp_ch.status,
					rsp_ch.entries_held);
				errors++;
			end else begin
				want = replies_pending.pop_front();
				if (rsp_ch.found !== want.found) begin
					$display("%0t: found mismatch: expected %0b actual %0b",
						$time, want.found, rsp_ch.found);
					errors++;
				end
				if (rsp_ch.result_entry !== want.entry) begin
					$display("%0t: result_entry mismatch: expected %0d actual %0d",
						$time, want.entry, rsp_ch.result_entry);
					errors++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.entries_held !== want.held) begin
					$display("%0t: entries_held mismatch: expected %0d actual %0d",
						$time, want.held, rsp_ch.entries_held);
					errors++;
				end
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		dir_row_t    dir_rows[$];
		int unsigned sent;
		int unsigned n_app;
		int unsigned n_ops;
		int unsigned r;
		bit          first_pass;

		errors = 0;
		no_idle = 1'b0;
		near_base = '0;
		tbl_count = 0;
		tbl_incl = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_CLEAR;
		req_ch.region_start = '0;
		req_ch.region_end = '0;
		req_ch.target_entry = '0;
		req_ch.query_address = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd0));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd0, '0, 1'b1, 1'b0, 6'd0, ST_RANGE, 7'd0));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd63, '0, 1'b1, 1'b0, 6'd63, ST_RANGE, 7'd0));
		// full address span
		dir_rows.push_back(drow(CMD_APPEND, '0, '1, '0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, '1, 1'b1, 1'b1, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_FIND, '1, '1, '1, '0, 1'b1, 1'b1, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_CLEAR, '1, '1, '1, '1, 1'b1, 1'b0, 6'd0, ST_OK, 7'd0));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd5, 1'b1, 1'b0, 6'd0, ST_OK, 7'd0));
		// top-address region, start above end, equal-start tie
		dir_rows.push_back(drow(CMD_APPEND, '1, '1, '0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd1));
		dir_rows.push_back(drow(CMD_APPEND, 32'd200, 32'd100, '0, '0, 1'b1, 1'b0, 6'd1, ST_OK,
			7'd2));
		dir_rows.push_back(drow(CMD_APPEND, 32'd150, 32'd300, '0, '0, 1'b1, 1'b0, 6'd2, ST_OK,
			7'd3));
		dir_rows.push_back(drow(CMD_APPEND, 32'd150, 32'd400, '0, '0, 1'b1, 1'b0, 6'd3, ST_OK,
			7'd4));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd0, '0, 1'b1, 1'b0, 6'd0, ST_OK, 7'd4));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd1, '0, 1'b1, 1'b0, 6'd1, ST_OK, 7'd4));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd3, '0, 1'b1, 1'b0, 6'd3, ST_OK, 7'd4));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd50, 1'b0, 1'b0, '0, ST_OK, '0));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd2, '0, 1'b1, 1'b0, 6'd2, ST_OK, 7'd4));
		dir_rows.push_back(drow(CMD_MARK, '0, '0, 6'd4, '0, 1'b1, 1'b0, 6'd4, ST_RANGE, 7'd4));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd50, 1'b0, 1'b0, '0, ST_OK, '0));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd120, 1'b0, 1'b0, '0, ST_OK, '0));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd350, 1'b0, 1'b0, '0, ST_OK, '0));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, 32'd500, 1'b0, 1'b0, '0, ST_OK, '0));
		dir_rows.push_back(drow(CMD_FIND, '0, '0, '0, '1, 1'b0, 1'b0, '0, ST_OK, '0));

		foreach (dir_rows[i])
			issue_cmd(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);

		// random part: episodes of table setup followed by mixed traffic;
		// the first episode appends 62 to 70 regions, which can overfill the table
		sent = 0;
		first_pass = 1'b1;
		while (sent < 950) begin
			no_idle = ($urandom_range(0, 4) == 0);
			near_base = $urandom();
			if (first_pass || $urandom_range(0, 3) != 0) begin
				issue_rand(rand_fields(CMD_CLEAR));
				sent++;
			end
			if (first_pass || $urandom_range(0, 9) == 0)
				n_app = $urandom_range(62, 70);
			else
				n_app = $urandom_range(1, 12);
			first_pass = 1'b0;
			repeat (n_app) begin
				issue_rand(rand_append());
				sent++;
			end
			n_ops = $urandom_range(8, 30);
			repeat (n_ops) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					issue_rand(rand_mark(1'b0));
				else if (r < 85)
					issue_rand(rand_find());
				else if (r < 93)
					issue_rand(rand_append());
				else if (r < 96)
					issue_rand(rand_fields(CMD_CLEAR));
				else
					issue_rand(rand_mark(1'b1));
				sent++;
			end
		end
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;

		while (replies_pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
